@@ hw/rtl/vdp_pkg.sv @@
// shared types and codes for the vdp cpu port interface
// no dependencies; imported by vdp_core, vdp_cpu_port_interface and the testbench
`default_nettype none
package vdp_pkg;

   // command codes on the request channel
   localparam logic [2:0] CMD_STATUS   = 3'd0;
   localparam logic [2:0] CMD_DREAD    = 3'd1;
   localparam logic [2:0] CMD_DWRITE   = 3'd2;
   localparam logic [2:0] CMD_CONTROL  = 3'd3;
   localparam logic [2:0] CMD_PALETTE  = 3'd4;
   localparam logic [2:0] CMD_INDIRECT = 3'd5;
   localparam logic [2:0] CMD_MEMRET   = 3'd6;
   localparam logic [2:0] CMD_EVENTS   = 3'd7;

   // memory request codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   // exported write kinds
   localparam logic [1:0] WR_NONE    = 2'd0;
   localparam logic [1:0] WR_REG     = 2'd1;
   localparam logic [1:0] WR_PALETTE = 2'd2;

   // registers that act inside the block
   localparam logic [5:0] REG_MODE0    = 6'h00;
   localparam logic [5:0] REG_MODE1    = 6'h01;
   localparam logic [5:0] REG_BANK     = 6'h0E;
   localparam logic [5:0] REG_STATSEL  = 6'h0F;
   localparam logic [5:0] REG_PALIDX   = 6'h10;
   localparam logic [5:0] REG_INDIRECT = 6'h11;
   localparam logic [5:0] REG_COLOUR   = 6'h2C;
   localparam logic [5:0] REG_ARGUMENT = 6'h2D;

   // status register indexes
   localparam logic [3:0] STAT_FLAGS   = 4'd0;
   localparam logic [3:0] STAT_IRQ     = 4'd1;
   localparam logic [3:0] STAT_LIVE    = 4'd2;
   localparam logic [3:0] STAT_FILL4   = 4'd4;
   localparam logic [3:0] STAT_FILL6   = 4'd6;
   localparam logic [3:0] STAT_COLOUR  = 4'd7;
   localparam logic [3:0] STAT_MATCHLO = 4'd8;
   localparam logic [3:0] STAT_MATCHHI = 4'd9;

   localparam logic [7:0] STAT_FILL_BYTE = 8'hFE;
   localparam logic [4:0] OVN_NONE       = 5'b11111;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] wdata;
      logic [6:0] raise_flags;
      logic [4:0] overflow_index;
      logic [4:0] live_status;
      logic [8:0] border_match;
   } vdp_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [1:0]  mem_request;
      logic [16:0] mem_address;
      logic        mem_select;
      logic [7:0]  mem_wdata;
      logic [1:0]  write_kind;
      logic [5:0]  write_index;
      logic [8:0]  write_value;
      logic        irq_line;
   } vdp_result_type;

endpackage
`default_nettype wire

@@ hw/rtl/vdp_cpu_port_interface.sv @@
// top level of the vdp cpu port interface: request register, core, response register
// depends on vdp_pkg and vdp_core
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    cmd, wdata, raise_flags, overflow_index,
//                                          live_status, border_match
//   rsp_     out        rsp_valid/stall    read_data, mem_*, write_kind/index/value,
//                                          irq_line
//
// one beat in, one beat out; a new request beat can be taken every cycle while req_stall is low
// a beat passes through the request register, then the core decode into the response register
// the core updates its state only when its beat moves into the response register
// a stalled response holds the request register, and req_stall rises only then
// reset is synchronous and active high; it clears the core state and both valid flags, not the payload
`default_nettype none
module vdp_cpu_port_interface
   import vdp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [6:0]  req_raise_flags,
   input  wire logic [4:0]  req_overflow_index,
   input  wire logic [4:0]  req_live_status,
   input  wire logic [8:0]  req_border_match,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_mem_request,
   output logic [16:0]      rsp_mem_address,
   output logic             rsp_mem_select,
   output logic [7:0]       rsp_mem_wdata,
   output logic [1:0]       rsp_write_kind,
   output logic [5:0]       rsp_write_index,
   output logic [8:0]       rsp_write_value,
   output logic             rsp_irq_line
);

   // request register
   logic            in_valid_ff, in_valid_in;
   vdp_item_type    in_item_ff, in_item_in;

   // response register
   logic            out_valid_ff, out_valid_in;
   vdp_result_type  out_res_ff, out_res_in;

   logic            advance;
   logic            step;
   logic            take;
   vdp_result_type  core_res;

   // the response slot is free or being emptied this cycle
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   always_comb begin
      in_item_in = in_item_ff;
      if (take) begin
         in_item_in = '{cmd:            req_cmd,
                        wdata:          req_wdata,
                        raise_flags:    req_raise_flags,
                        overflow_index: req_overflow_index,
                        live_status:    req_live_status,
                        border_match:   req_border_match};
      end
      // hold while stalled, else refill or drain
      in_valid_in = req_stall ? in_valid_ff : req_valid;

      out_res_in = step ? core_res : out_res_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   vdp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = out_res_ff.read_data;
   assign rsp_mem_request = out_res_ff.mem_request;
   assign rsp_mem_address = out_res_ff.mem_address;
   assign rsp_mem_select  = out_res_ff.mem_select;
   assign rsp_mem_wdata   = out_res_ff.mem_wdata;
   assign rsp_write_kind  = out_res_ff.write_kind;
   assign rsp_write_index = out_res_ff.write_index;
   assign rsp_write_value = out_res_ff.write_value;
   assign rsp_irq_line    = out_res_ff.irq_line;

endmodule
`default_nettype wire

@@ hw/rtl/vdp_core.sv @@
// port state registers and the single-pass decode of one command
// depends on vdp_pkg
`default_nettype none
module vdp_core
   import vdp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire vdp_item_type   item,
   output vdp_result_type      result
);

   logic [15:0] cw_ff, cw_in;
   logic        cphase_ff, cphase_in;
   logic [2:0]  bank_ff, bank_in;
   logic        choice_ff, choice_in;
   logic [7:0]  latch_ff, latch_in;
   logic [3:0]  statsel_ff, statsel_in;
   logic [3:0]  palidx_ff, palidx_in;
   logic [7:0]  palbyte_ff, palbyte_in;
   logic        pphase_ff, pphase_in;
   logic [5:0]  indidx_ff, indidx_in;
   logic        indfix_ff, indfix_in;
   logic [2:0]  irqen_ff, irqen_in;
   logic [2:0]  irqpend_ff, irqpend_in;
   logic [1:0]  sflags_ff, sflags_in;
   logic [4:0]  ovn_ff, ovn_in;
   logic [7:0]  colour_ff, colour_in;
   logic        ready_ff, ready_in;

   logic        ma_en;
   logic [1:0]  ma_kind;
   logic [13:0] ma_low;
   logic        rw_en;
   logic [5:0]  rw_idx;
   logic [7:0]  rw_val;

   always_comb begin
      cw_in      = cw_ff;
      cphase_in  = cphase_ff;
      bank_in    = bank_ff;
      choice_in  = choice_ff;
      latch_in   = latch_ff;
      statsel_in = statsel_ff;
      palidx_in  = palidx_ff;
      palbyte_in = palbyte_ff;
      pphase_in  = pphase_ff;
      indidx_in  = indidx_ff;
      indfix_in  = indfix_ff;
      irqen_in   = irqen_ff;
      irqpend_in = irqpend_ff;
      sflags_in  = sflags_ff;
      ovn_in     = ovn_ff;
      colour_in  = colour_ff;
      ready_in   = ready_ff;
      result     = '0;
      ma_en      = 1'b0;
      ma_kind    = MEM_NONE;
      ma_low     = '0;
      rw_en      = 1'b0;
      rw_idx     = '0;
      rw_val     = '0;

      case (item.cmd)
         CMD_STATUS: begin
            cphase_in = 1'b0;
            case (statsel_ff)
               STAT_FLAGS: begin
                  result.read_data = {irqpend_ff[0], sflags_ff[1], sflags_ff[0], ovn_ff};
                  ovn_in        = OVN_NONE;
                  sflags_in     = '0;
                  irqpend_in[0] = 1'b0;
               end
               STAT_IRQ: begin
                  result.read_data = {irqpend_ff[2], 6'b0, irqpend_ff[1]};
                  irqpend_in[2:1]  = 2'b00;
               end
               STAT_LIVE: begin
                  result.read_data = {ready_ff, item.live_status[4:2], 2'b11,
                                      item.live_status[1:0]};
               end
               STAT_FILL4, STAT_FILL6: result.read_data = STAT_FILL_BYTE;
               STAT_COLOUR: begin
                  result.read_data = colour_ff;
                  ready_in         = 1'b0;
               end
               STAT_MATCHLO: result.read_data = item.border_match[7:0];
               STAT_MATCHHI: result.read_data = {7'b1111111, item.border_match[8]};
               default:      result.read_data = '0;
            endcase
         end
         CMD_DREAD: begin
            cphase_in        = 1'b0;
            result.read_data = latch_ff;
            ma_en            = 1'b1;
            ma_kind          = MEM_READ;
         end
         CMD_DWRITE: begin
            cphase_in        = 1'b0;
            ma_en            = 1'b1;
            ma_kind          = MEM_WRITE;
            result.mem_wdata = item.wdata;
         end
         CMD_CONTROL: begin
            if (!cphase_ff) begin
               cw_in     = {cw_ff[15:8], item.wdata};
               cphase_in = 1'b1;
            end else begin
               cw_in     = {item.wdata, cw_ff[7:0]};
               cphase_in = 1'b0;
               if (item.wdata[7]) begin
                  rw_en  = 1'b1;
                  rw_idx = item.wdata[5:0];
                  rw_val = cw_ff[7:0];
               end else if (!item.wdata[6]) begin
                  // read-ahead
                  ma_en   = 1'b1;
                  ma_kind = MEM_READ;
               end
            end
         end
         CMD_PALETTE: begin
            if (!pphase_ff) begin
               palbyte_in = item.wdata;
               pphase_in  = 1'b1;
            end else begin
               pphase_in          = 1'b0;
               result.write_kind  = WR_PALETTE;
               result.write_index = {2'b00, palidx_ff};
               result.write_value = {item.wdata[2:0], palbyte_ff[6:4], palbyte_ff[2:0]};
               palidx_in          = palidx_ff + 4'd1;
            end
         end
         CMD_INDIRECT: begin
            if (indidx_ff != REG_INDIRECT) begin
               rw_en  = 1'b1;
               rw_idx = indidx_ff;
               rw_val = item.wdata;
            end
            if (!indfix_ff) begin
               indidx_in = indidx_ff + 6'd1;
            end
         end
         CMD_MEMRET: latch_in = item.wdata;
         default: begin
            irqpend_in = irqpend_ff | (item.raise_flags[2:0] & irqen_ff);
            if (item.raise_flags[3]) begin
               sflags_in[0] = 1'b1;
            end
            if (item.raise_flags[4]) begin
               sflags_in[1] = 1'b1;
               ovn_in       = item.overflow_index;
            end
            if (item.raise_flags[5]) begin
               ready_in = 1'b1;
            end
            if (item.raise_flags[6]) begin
               colour_in = item.wdata;
            end
         end
      endcase

      // video memory access through the auto-incrementing address
      if (ma_en) begin
         result.mem_request = ma_kind;
         result.mem_address = {bank_in, cw_in[13:0]};
         result.mem_select  = choice_in;
         ma_low             = cw_in[13:0] + 14'd1;
         cw_in              = {cw_in[15:14], ma_low};
         if (ma_low == '0) begin
            bank_in = bank_in + 3'd1;
         end
      end

      // register write: exported, and a few act here
      if (rw_en) begin
         result.write_kind  = WR_REG;
         result.write_index = rw_idx;
         result.write_value = {1'b0, rw_val};
         case (rw_idx)
            REG_MODE0: begin
               irqen_in   = {rw_val[5], rw_val[4], irqen_in[0]};
               irqpend_in = irqpend_in & irqen_in;
            end
            REG_MODE1: begin
               irqen_in   = {irqen_in[2:1], rw_val[5]};
               irqpend_in = irqpend_in & irqen_in;
            end
            REG_BANK:     bank_in    = rw_val[2:0];
            REG_STATSEL:  statsel_in = rw_val[3:0];
            REG_PALIDX:   palidx_in  = rw_val[3:0];
            REG_INDIRECT: begin
               indidx_in = rw_val[5:0];
               indfix_in = rw_val[7];
            end
            REG_COLOUR: begin
               colour_in = rw_val;
               ready_in  = 1'b0;
            end
            REG_ARGUMENT: choice_in = rw_val[6];
            default: ;
         endcase
      end

      result.irq_line = |(irqpend_in & irqen_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff      <= '0;
         cphase_ff  <= 1'b0;
         bank_ff    <= '0;
         choice_ff  <= 1'b0;
         latch_ff   <= '0;
         statsel_ff <= '0;
         palidx_ff  <= '0;
         palbyte_ff <= '0;
         pphase_ff  <= 1'b0;
         indidx_ff  <= '0;
         indfix_ff  <= 1'b0;
         irqen_ff   <= '0;
         irqpend_ff <= '0;
         sflags_ff  <= '0;
         ovn_ff     <= OVN_NONE;
         colour_ff  <= '0;
         ready_ff   <= 1'b0;
      end else if (step) begin
         cw_ff      <= cw_in;
         cphase_ff  <= cphase_in;
         bank_ff    <= bank_in;
         choice_ff  <= choice_in;
         latch_ff   <= latch_in;
         statsel_ff <= statsel_in;
         palidx_ff  <= palidx_in;
         palbyte_ff <= palbyte_in;
         pphase_ff  <= pphase_in;
         indidx_ff  <= indidx_in;
         indfix_ff  <= indfix_in;
         irqen_ff   <= irqen_in;
         irqpend_ff <= irqpend_in;
         sflags_ff  <= sflags_in;
         ovn_ff     <= ovn_in;
         colour_ff  <= colour_in;
         ready_ff   <= ready_in;
      end
   end

endmodule
`default_nettype wire

@@ test/vdp_cpu_port_interface_test.sv @@
// self-checking testbench for vdp_cpu_port_interface: status, data, control, palette,
// indirect and event commands, each checked against an in-bench model of the port state
// depends on vdp_pkg and the vdp_cpu_port_interface rtl
`default_nettype none
module vdp_cpu_port_interface_test;
   import vdp_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   // registers whose writes act inside the block, picked often by the random traffic
   localparam logic [5:0] ACTING_REGS [8] = '{REG_MODE0, REG_MODE1, REG_BANK, REG_STATSEL,
                                              REG_PALIDX, REG_INDIRECT, REG_COLOUR,
                                              REG_ARGUMENT};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_STATUS;
   logic [7:0]  req_wdata = '0;
   logic [6:0]  req_raise_flags = '0;
   logic [4:0]  req_overflow_index = '0;
   logic [4:0]  req_live_status = '0;
   logic [8:0]  req_border_match = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_mem_request;
   logic [16:0] rsp_mem_address;
   logic        rsp_mem_select;
   logic [7:0]  rsp_mem_wdata;
   logic [1:0]  rsp_write_kind;
   logic [5:0]  rsp_write_index;
   logic [8:0]  rsp_write_value;
   logic        rsp_irq_line;

   vdp_cpu_port_interface i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_wdata          (req_wdata),
      .req_raise_flags    (req_raise_flags),
      .req_overflow_index (req_overflow_index),
      .req_live_status    (req_live_status),
      .req_border_match   (req_border_match),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_mem_request    (rsp_mem_request),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_mem_select     (rsp_mem_select),
      .rsp_mem_wdata      (rsp_mem_wdata),
      .rsp_write_kind     (rsp_write_kind),
      .rsp_write_index    (rsp_write_index),
      .rsp_write_value    (rsp_write_value),
      .rsp_irq_line       (rsp_irq_line)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // port state as the cpu sees it, starting from the reset values
   // ---------------------------------------------------------------------------------------
   logic [15:0] ctl_word   = '0;
   logic        ctl_second = 1'b0;   // first control byte taken, waiting for the second
   logic [2:0]  vram_bank  = '0;
   logic        vram_sel   = 1'b0;   // expansion memory chosen
   logic [7:0]  prefetch   = '0;
   logic [3:0]  stat_sel   = '0;
   logic [3:0]  pal_idx    = '0;
   logic [7:0]  pal_lo     = '0;
   logic        pal_second = 1'b0;
   logic [5:0]  ind_idx    = '0;
   logic        ind_fixed  = 1'b0;
   logic [2:0]  irq_en     = '0;     // bit 0 vertical, 1 horizontal, 2 light
   logic [2:0]  irq_pend   = '0;
   logic [1:0]  spr_flags  = '0;     // bit 0 collision, 1 overflow
   logic [4:0]  ovf_num    = OVN_NONE;
   logic [7:0]  colour     = '0;
   logic        engine_rdy = 1'b0;

   vdp_result_type due_results[$];
   int  mismatches = 0;
   int  beats_sent = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;                // no idling on either side

   // memory access at the current address, then post-increment with carry into the bank
   task automatic vram_access(inout vdp_result_type r, input logic [1:0] kind,
                              input logic [7:0] wbyte);
      logic [13:0] low;
      low = ctl_word[13:0];
      r.mem_request = kind;
      r.mem_address = {vram_bank, low};
      r.mem_select  = vram_sel;
      r.mem_wdata   = wbyte;
      low = low + 14'd1;
      ctl_word[13:0] = low;
      if (low == 14'd0) vram_bank = vram_bank + 3'd1;
   endtask

   // every register write goes out; only a handful change the port itself
   task automatic reg_store(inout vdp_result_type r, input logic [5:0] idx,
                            input logic [7:0] val);
      r.write_kind  = WR_REG;
      r.write_index = idx;
      r.write_value = {1'b0, val};
      case (idx)
         REG_MODE0: begin
            irq_en[1] = val[4];
            irq_en[2] = val[5];
            irq_pend &= irq_en;
         end
         REG_MODE1: begin
            irq_en[0] = val[5];
            irq_pend &= irq_en;
         end
         REG_BANK:     vram_bank = val[2:0];
         REG_STATSEL:  stat_sel = val[3:0];
         REG_PALIDX:   pal_idx = val[3:0];
         REG_INDIRECT: begin
            ind_idx   = val[5:0];
            ind_fixed = val[7];
         end
         REG_COLOUR: begin
            colour     = val;
            engine_rdy = 1'b0;
         end
         REG_ARGUMENT: vram_sel = val[6];
         default: ;
      endcase
   endtask

   // one command in, the response beat it must produce out
   task automatic port_step(input vdp_item_type it, output vdp_result_type r);
      r = '0;
      case (it.cmd)
         CMD_STATUS: begin
            ctl_second = 1'b0;
            case (stat_sel)
               STAT_FLAGS: begin
                  // read clears vertical pending, sprite flags and overflow number
                  r.read_data = {irq_pend[0], spr_flags[1], spr_flags[0], ovf_num};
                  ovf_num     = OVN_NONE;
                  spr_flags   = '0;
                  irq_pend[0] = 1'b0;
               end
               STAT_IRQ: begin
                  r.read_data   = {irq_pend[2], 6'd0, irq_pend[1]};
                  irq_pend[2:1] = 2'b00;
               end
               STAT_LIVE: r.read_data = {engine_rdy, it.live_status[4:2], 2'b11,
                                         it.live_status[1:0]};
               STAT_FILL4, STAT_FILL6: r.read_data = STAT_FILL_BYTE;
               STAT_COLOUR: begin
                  r.read_data = colour;
                  engine_rdy  = 1'b0;
               end
               STAT_MATCHLO: r.read_data = it.border_match[7:0];
               STAT_MATCHHI: r.read_data = {7'b1111111, it.border_match[8]};
               default: r.read_data = '0;
            endcase
         end
         CMD_DREAD: begin
            ctl_second  = 1'b0;
            r.read_data = prefetch;
            vram_access(r, MEM_READ, 8'd0);
         end
         CMD_DWRITE: begin
            ctl_second = 1'b0;
            vram_access(r, MEM_WRITE, it.wdata);
         end
         CMD_CONTROL: begin
            if (!ctl_second) begin
               ctl_word[7:0] = it.wdata;
               ctl_second    = 1'b1;
            end else begin
               ctl_word[15:8] = it.wdata;
               ctl_second     = 1'b0;
               if (ctl_word[15]) reg_store(r, ctl_word[13:8], ctl_word[7:0]);
               else if (!ctl_word[14]) vram_access(r, MEM_READ, 8'd0);  // read-ahead
            end
         end
         CMD_PALETTE: begin
            if (!pal_second) begin
               pal_lo     = it.wdata;
               pal_second = 1'b1;
            end else begin
               // green from the second byte, red and blue from the first
               pal_second    = 1'b0;
               r.write_kind  = WR_PALETTE;
               r.write_index = {2'b00, pal_idx};
               r.write_value = {it.wdata[2:0], pal_lo[6:4], pal_lo[2:0]};
               pal_idx       = pal_idx + 4'd1;
            end
         end
         CMD_INDIRECT: begin
            // the indirect index register itself cannot be written this way
            if (ind_idx != REG_INDIRECT) reg_store(r, ind_idx, it.wdata);
            if (!ind_fixed) ind_idx = ind_idx + 6'd1;
         end
         CMD_MEMRET: prefetch = it.wdata;
         CMD_EVENTS: begin
            irq_pend |= it.raise_flags[2:0] & irq_en;
            if (it.raise_flags[3]) spr_flags[0] = 1'b1;
            if (it.raise_flags[4]) begin
               spr_flags[1] = 1'b1;
               ovf_num      = it.overflow_index;
            end
            if (it.raise_flags[5]) engine_rdy = 1'b1;
            if (it.raise_flags[6]) colour = it.wdata;
         end
         default: ;
      endcase
      r.irq_line = |(irq_pend & irq_en);
   endtask

   // ---------------------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------------------

   // drive one beat, hold it through stalls, and queue its response once accepted
   task automatic send_op(input logic [2:0] cmd, input logic [7:0] data,
                          input logic [6:0] flags);
      vdp_item_type   it;
      vdp_result_type r;
      int             gap;
      it.cmd            = cmd;
      it.wdata          = data;
      it.raise_flags    = flags;
      it.overflow_index = 5'($urandom_range(0, 31));
      it.live_status    = 5'($urandom_range(0, 31));
      it.border_match   = 9'($urandom_range(0, 511));
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= it.cmd;
      req_wdata          <= it.wdata;
      req_raise_flags    <= it.raise_flags;
      req_overflow_index <= it.overflow_index;
      req_live_status    <= it.live_status;
      req_border_match   <= it.border_match;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      port_step(it, r);
      due_results.push_back(r);
      beats_sent++;
   endtask

   task automatic send_ctl(input logic [7:0] lo, input logic [7:0] hi);
      send_op(CMD_CONTROL, lo, 7'($urandom_range(0, 127)));
      send_op(CMD_CONTROL, hi, 7'($urandom_range(0, 127)));
   endtask

   // register write through the control port: second byte carries bit 15 and the index
   task automatic set_reg(input logic [5:0] idx, input logic [7:0] val);
      send_ctl(val, {2'b10, idx});
   endtask

   task automatic send_plain(input logic [2:0] cmd, input logic [7:0] data);
      send_op(cmd, data, 7'($urandom_range(0, 127)));
   endtask

   // stop sending and let every queued response come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // one well-formed access sequence with random content, or now and then a stray beat
   task automatic random_sequence();
      int         pick;
      int         n;
      logic [5:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         if ($urandom_range(0, 1) == 1) idx = ACTING_REGS[$urandom_range(0, 7)];
         else idx = 6'($urandom_range(0, 63));
         send_ctl(8'($urandom_range(0, 255)), {1'b1, 1'($urandom_range(0, 1)), idx});
      end else if (pick < 30) begin
         // address set, often just below a 16k boundary so the bank carry shows up
         if ($urandom_range(0, 2) == 0)
            send_ctl(8'($urandom_range(248, 255)), {1'b0, 1'($urandom_range(0, 1)), 6'h3F});
         else
            send_ctl(8'($urandom_range(0, 255)),
                     {1'b0, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))});
      end else if (pick < 45) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            if ($urandom_range(0, 1) == 1) begin
               send_plain(CMD_DREAD, 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 1) == 1) send_plain(CMD_MEMRET, 8'($urandom_range(0, 255)));
            end else begin
               send_plain(CMD_DWRITE, 8'($urandom_range(0, 255)));
            end
         end
      end else if (pick < 55) begin
         send_plain(CMD_PALETTE, 8'($urandom_range(0, 255)));
         send_plain(CMD_PALETTE, 8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
         n = $urandom_range(1, 4);
         repeat (n) send_plain(CMD_INDIRECT, 8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
         send_plain(CMD_EVENTS, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
         send_plain(CMD_STATUS, 8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
         send_plain(CMD_MEMRET, 8'($urandom_range(0, 255)));
      end else begin
         // stray beat of any kind, breaks up half-done byte pairs
         send_plain(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // raised flags without enables stay clear, with enables they drive the irq line
   task automatic test_irq_flags();
      send_op(CMD_EVENTS, 8'hFF, 7'h7F);
      set_reg(REG_MODE0, 8'h30);
      set_reg(REG_MODE1, 8'h20);
      send_op(CMD_EVENTS, 8'hA5, 7'h7F);
      send_plain(CMD_STATUS, 8'h00);     // flags status, clears on read
   endtask

   // pin the indirect port onto the status select register and walk a few indexes
   task automatic test_status_port();
      set_reg(REG_INDIRECT, {2'b10, REG_STATSEL});
      send_plain(CMD_INDIRECT, {4'h0, STAT_IRQ});
      send_plain(CMD_STATUS, 8'h00);
      send_plain(CMD_INDIRECT, {4'h0, STAT_MATCHHI});
      send_plain(CMD_STATUS, 8'hFF);
      send_plain(CMD_INDIRECT, 8'h0C);   // unused index reads zero
      send_plain(CMD_STATUS, 8'h00);
   endtask

   // auto-increment from index 17: that write is dropped, the index still moves on
   task automatic test_indirect_port();
      set_reg(REG_INDIRECT, {2'b00, REG_INDIRECT});
      send_plain(CMD_INDIRECT, 8'hFF);
   endtask

   // read-ahead at the top of the first bank, prefetch return, reads and writes
   task automatic test_data_port();
      send_ctl(8'hFF, 8'h3F);
      send_plain(CMD_MEMRET, 8'h5A);
      send_plain(CMD_DREAD, 8'h00);
      send_plain(CMD_DWRITE, 8'hFF);
      send_ctl(8'h00, 8'h40);            // address only, no read-ahead
      send_plain(CMD_DWRITE, 8'h00);
   endtask

   task automatic test_palette_port();
      send_plain(CMD_PALETTE, 8'hFF);
      send_plain(CMD_PALETTE, 8'hFF);
   endtask

   // bulk random traffic with a full drain halfway through
   task automatic test_random_traffic();
      while (beats_sent < 800) random_sequence();
      hold_until_drained();
      while (beats_sent < 1500) random_sequence();
   endtask

   // back-to-back beats with the response side never stalled
   task automatic test_quiet_tail();
      quiet = 1'b1;
      while (beats_sent < 1650) random_sequence();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_irq_flags();
      test_status_port();
      test_indirect_port();
      test_data_port();
      test_palette_port();
      test_random_traffic();
      test_quiet_tail();
      hold_until_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------------------------

   // stall the response side now and then, in bursts of random length
   always @(posedge clock) begin
      if (quiet) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 40) $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatches++;
   endtask

   // compare each accepted response beat with the oldest one still due
   always @(posedge clock) begin : check_rsp
      vdp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            report_mismatch("response beat with none due", 1, 0);
         end else begin
            want = due_results.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", int'(rsp_read_data), int'(want.read_data));
            if (rsp_mem_request !== want.mem_request)
               report_mismatch("mem_request", int'(rsp_mem_request), int'(want.mem_request));
            if (rsp_mem_address !== want.mem_address)
               report_mismatch("mem_address", int'(rsp_mem_address), int'(want.mem_address));
            if (rsp_mem_select !== want.mem_select)
               report_mismatch("mem_select", int'(rsp_mem_select), int'(want.mem_select));
            if (rsp_mem_wdata !== want.mem_wdata)
               report_mismatch("mem_wdata", int'(rsp_mem_wdata), int'(want.mem_wdata));
            if (rsp_write_kind !== want.write_kind)
               report_mismatch("write_kind", int'(rsp_write_kind), int'(want.write_kind));
            if (rsp_write_index !== want.write_index)
               report_mismatch("write_index", int'(rsp_write_index), int'(want.write_index));
            if (rsp_write_value !== want.write_value)
               report_mismatch("write_value", int'(rsp_write_value), int'(want.write_value));
            if (rsp_irq_line !== want.irq_line)
               report_mismatch("irq_line", int'(rsp_irq_line), int'(want.irq_line));
         end
      end
   end

   // watchdog: too long with no beat moving on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
`default_nettype wire
